// File: hw/rtl/rbs_pkg.sv
// Package for the ray versus box slab test.
// Holds default widths and the configuration register indexes; no dependencies.
`timescale 1ns / 1ps
package rbs_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } t_cfg_idx;
endpackage

// File: hw/rtl/rbs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on rbs_pkg for default widths.
`timescale 1ns / 1ps
module rbs_div
    import rbs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [COORD_WIDTH:0]          i_num,
    input  logic [COORD_WIDTH-1:0]        i_den,
    input  logic                          i_neg,
    output logic signed [COORD_WIDTH-1:0] o_quot
);
    localparam int QW  = COORD_WIDTH - 1;
    localparam int NW  = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int DW2 = 2 * COORD_WIDTH - 1;
    localparam int SW  = (NW > DW2) ? NW : DW2;

    logic [SW-1:0]          r_rem [QW+1];
    logic [COORD_WIDTH-1:0] r_den [QW+1];
    logic [QW-1:0]          r_q   [QW+1];
    logic                   r_neg [QW+1];
    logic                   r_sat [QW+1];
    logic [SW-1:0]          w_num;
    logic [QW-1:0]          w_mag;

    assign w_num = SW'(i_num) << FRAC_BITS;

    // Stage zero aligns the scaled numerator and flags a saturating quotient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_sat[0] <= w_num >= (SW'(i_den) << QW);
        end
    end

    // Each stage decides one quotient bit, most significant first.
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [SW-1:0] w_sub;
        logic          w_ge;
        assign w_sub = SW'(r_den[k-1]) << (QW - k);
        assign w_ge  = r_rem[k-1] >= w_sub;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? r_rem[k-1] - w_sub : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][QW-2:0], w_ge};
                r_neg[k] <= r_neg[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    // Saturate and apply the sign.
    assign w_mag = r_sat[QW] ? {QW{1'b1}} : r_q[QW];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quot <= r_neg[QW] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end
endmodule

// File: hw/rtl/rbs_delay.sv
// Sideband delay line that keeps flags and valid bits aligned with the divider.
// Depends on rbs_pkg only through the common import style.
`timescale 1ns / 1ps
module rbs_delay
    import rbs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_data  [DEPTH];
    logic [DEPTH-1:0] r_valid;

    // Valid bits are cleared by reset; data needs none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];
endmodule

// File: hw/rtl/rbs_slab.sv
// One axis: near and far ray parameters from two quotients or an unbounded slab.
// Depends on rbs_pkg for default widths.
`timescale 1ns / 1ps
module rbs_slab
    import rbs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_t1,
    input  logic signed [COORD_WIDTH-1:0] i_t2,
    input  logic                          i_dir_zero,
    input  logic                          i_inside,
    output logic signed [COORD_WIDTH:0]   o_near,
    output logic signed [COORD_WIDTH:0]   o_far,
    output logic                          o_miss
);
    localparam logic signed [COORD_WIDTH:0] UNB_LO = {2'b11, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH:0] UNB_HI = {2'b01, {(COORD_WIDTH-1){1'b0}}};

    logic w_lt;
    assign w_lt = i_t1 < i_t2;

    // A zero direction leaves the axis unbounded, or misses outright.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_dir_zero) begin
                o_near <= UNB_LO;
                o_far  <= UNB_HI;
                o_miss <= !i_inside;
            end else begin
                o_near <= (COORD_WIDTH+1)'(w_lt ? i_t1 : i_t2);
                o_far  <= (COORD_WIDTH+1)'(w_lt ? i_t2 : i_t1);
                o_miss <= 1'b0;
            end
        end
    end
endmodule

// File: hw/rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test, top level.
// The pipeline has one input stage, the COORD_WIDTH + 1 stages of the bit-per-stage
// dividers, one slab stage and one output stage.
// Throughput is one request per cycle; an output stall freezes the whole pipeline.
// Synchronous active-low reset clears the valid bits and the box corners to zero.
`timescale 1ns / 1ps
module ray_box_slab_intersect
    import rbs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  logic signed [COORD_WIDTH-1:0] i_max_distance,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [COORD_WIDTH-2:0]        o_hit_distance
);
    localparam int DIV_LAT = COORD_WIDTH + 1;
    localparam int SB_W    = 6 + COORD_WIDTH;

    logic signed [COORD_WIDTH-1:0] r_box_lo [3];
    logic signed [COORD_WIDTH-1:0] r_box_hi [3];
    logic signed [COORD_WIDTH-1:0] w_org [3];
    logic signed [COORD_WIDTH-1:0] w_dir [3];
    logic                          w_en;

    // Stage A registers.
    logic [COORD_WIDTH:0]          r_num_lo [3];
    logic [COORD_WIDTH:0]          r_num_hi [3];
    logic [COORD_WIDTH-1:0]        r_den    [3];
    logic                          r_neg_lo [3];
    logic                          r_neg_hi [3];
    logic [2:0]                    r_dz;
    logic [2:0]                    r_in;
    logic signed [COORD_WIDTH-1:0] r_maxd_a;
    logic                          r_valid_a;

    logic signed [COORD_WIDTH-1:0] w_t1 [3];
    logic signed [COORD_WIDTH-1:0] w_t2 [3];
    logic                          w_valid_d;
    logic [SB_W-1:0]               w_sb_d;

    logic signed [COORD_WIDTH:0]   w_near [3];
    logic signed [COORD_WIDTH:0]   w_far  [3];
    logic                          w_miss [3];
    logic signed [COORD_WIDTH-1:0] r_maxd_s;
    logic                          r_valid_s;

    logic signed [COORD_WIDTH:0]   w_tmin;
    logic signed [COORD_WIDTH:0]   w_tmax;
    logic signed [COORD_WIDTH:0]   w_tmin_xy;
    logic signed [COORD_WIDTH:0]   w_tmax_xy;
    logic                          w_hit;
    logic                          r_valid_o;

    assign w_org = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};

    // The pipeline moves unless a finished result is held by the receiver.
    assign w_en    = !(r_valid_o && i_stall);
    assign o_stall = r_valid_o && i_stall;
    assign o_valid = r_valid_o;

    // Box corner registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box_lo[a] <= '0;
                r_box_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_MIN_X: r_box_lo[0] <= i_cfg_wdata;
                CFG_BOX_MIN_Y: r_box_lo[1] <= i_cfg_wdata;
                CFG_BOX_MIN_Z: r_box_lo[2] <= i_cfg_wdata;
                CFG_BOX_MAX_X: r_box_hi[0] <= i_cfg_wdata;
                CFG_BOX_MAX_Y: r_box_hi[1] <= i_cfg_wdata;
                CFG_BOX_MAX_Z: r_box_hi[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage A: slab plane offsets as magnitude and sign, plus zero-direction and inside flags.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [COORD_WIDTH:0] w_dlo;
        logic signed [COORD_WIDTH:0] w_dhi;
        logic signed [COORD_WIDTH:0] w_dsx;
        assign w_dlo = (COORD_WIDTH+1)'(r_box_lo[a]) - (COORD_WIDTH+1)'(w_org[a]);
        assign w_dhi = (COORD_WIDTH+1)'(r_box_hi[a]) - (COORD_WIDTH+1)'(w_org[a]);
        assign w_dsx = (COORD_WIDTH+1)'(w_dir[a]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_num_lo[a] <= w_dlo[COORD_WIDTH] ? -w_dlo : w_dlo;
                r_num_hi[a] <= w_dhi[COORD_WIDTH] ? -w_dhi : w_dhi;
                r_den[a]    <= COORD_WIDTH'(w_dir[a][COORD_WIDTH-1] ? -w_dsx : w_dsx);
                r_neg_lo[a] <= w_dlo[COORD_WIDTH] ^ w_dir[a][COORD_WIDTH-1];
                r_neg_hi[a] <= w_dhi[COORD_WIDTH] ^ w_dir[a][COORD_WIDTH-1];
                r_dz[a]     <= w_dir[a] == '0;
                r_in[a]     <= (w_org[a] >= r_box_lo[a]) && (w_org[a] <= r_box_hi[a]);
            end
        end

        rbs_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_num_lo[a]),
            .i_den  (r_den[a]),
            .i_neg  (r_neg_lo[a]),
            .o_quot (w_t1[a])
        );

        rbs_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_num_hi[a]),
            .i_den  (r_den[a]),
            .i_neg  (r_neg_hi[a]),
            .o_quot (w_t2[a])
        );

        rbs_slab #(.COORD_WIDTH(COORD_WIDTH)) u_slab (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_t1       (w_t1[a]),
            .i_t2       (w_t2[a]),
            .i_dir_zero (w_sb_d[a]),
            .i_inside   (w_sb_d[3+a]),
            .o_near     (w_near[a]),
            .o_far      (w_far[a]),
            .o_miss     (w_miss[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_maxd_a <= i_max_distance;
        end
    end

    // Valid bits for the input, slab and output stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_s <= 1'b0;
            r_valid_o <= 1'b0;
        end else if (w_en) begin
            r_valid_a <= i_valid;
            r_valid_s <= w_valid_d;
            r_valid_o <= r_valid_s;
        end
    end

    // Flags and the distance limit ride alongside the dividers.
    rbs_delay #(.WIDTH(SB_W), .DEPTH(DIV_LAT)) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_valid_a),
        .i_data  ({r_maxd_a, r_in, r_dz}),
        .o_valid (w_valid_d),
        .o_data  (w_sb_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_maxd_s <= w_sb_d[SB_W-1:6];
        end
    end

    // Combine the axes and decide the hit.
    assign w_tmin_xy = (w_near[0] > w_near[1]) ? w_near[0] : w_near[1];
    assign w_tmin    = (w_near[2] > w_tmin_xy) ? w_near[2] : w_tmin_xy;
    assign w_tmax_xy = (w_far[0] < w_far[1]) ? w_far[0] : w_far[1];
    assign w_tmax    = (w_far[2] < w_tmax_xy) ? w_far[2] : w_tmax_xy;
    assign w_hit = !(w_miss[0] || w_miss[1] || w_miss[2])
                   && (w_tmin > 0) && (w_tmax >= 0) && (w_tmax >= w_tmin)
                   && (w_tmin < (COORD_WIDTH+1)'(r_maxd_s));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit          <= w_hit;
            o_hit_distance <= w_hit ? w_tmin[COORD_WIDTH-2:0] : '0;
        end
    end
endmodule
